@@ rtl/ffba_pkg.sv @@
// Shared types and constants for the first-fit block allocator.
// No dependencies; used by first_fit_block_allocator.
`default_nettype none

package ffba_pkg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NOSPACE = 2'd1,
        STATUS_NOTAG   = 2'd2,
        STATUS_FULL    = 2'd3
    } status_t;

    // Request commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Heap size after reset
    localparam int HEAP_RESET = 1000;

endpackage

`default_nettype wire

@@ rtl/ffba_cell.sv @@
// One entry of the block table, a link in the rotating chain of cells.
// Depends on nothing; instantiated by first_fit_block_allocator.
`default_nettype none

module ffba_cell #(
    parameter int SIZE_BITS = 16,
    parameter int TAG_BITS = 16,
    parameter bit RESET_VALID = 1'b0,
    parameter logic [SIZE_BITS-1:0] RESET_SIZE = '0
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 shift,
    input  wire logic                 load,
    input  wire logic                 load_valid,
    input  wire logic [SIZE_BITS-1:0] load_size,
    input  wire logic                 in_valid,
    input  wire logic                 in_free,
    input  wire logic [SIZE_BITS-1:0] in_size,
    input  wire logic [TAG_BITS-1:0]  in_tag,
    output logic                      valid,
    output logic                      free,
    output logic [SIZE_BITS-1:0]      size,
    output logic [TAG_BITS-1:0]       tag
);

    logic                 valid_reg;
    logic                 free_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic [TAG_BITS-1:0]  tag_reg;

    // Take the neighbor's entry on shift, or a fresh one-block table on load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= RESET_VALID;
            free_reg  <= 1'b1;
            size_reg  <= RESET_SIZE;
        end
        else if (load)
        begin
            valid_reg <= load_valid;
            free_reg  <= 1'b1;
            size_reg  <= load_size;
        end
        else if (shift)
        begin
            valid_reg <= in_valid;
            free_reg  <= in_free;
            size_reg  <= in_size;
        end
    end

    // Tag is payload only
    always_ff @(posedge clk)
    begin
        if (load)
            tag_reg <= '0;
        else if (shift)
            tag_reg <= in_tag;
    end

    assign valid = valid_reg;
    assign free  = free_reg;
    assign size  = size_reg;
    assign tag   = tag_reg;

endmodule

`default_nettype wire

@@ rtl/first_fit_block_allocator.sv @@
// First-fit heap allocator: a rotating chain of table cells and a stream editor.
// Depends on ffba_pkg and ffba_cell.
// A zero or oversized allocate answers in the cycle after it is accepted; any
// other request rotates the whole chain once through the stream editor and then answers.
// Requests are taken only while idle; busy stays high through the chain rotation and the
// result state. Reset: one free block of 1000 (saturated to SIZE_BITS), next tag 1;
// a cfg_data write, taken when idle, rebuilds the table. The receiver cannot stall results.
`default_nettype none

module first_fit_block_allocator #(
    parameter int MAX_BLOCKS = 64,
    parameter int SIZE_BITS = 16,
    parameter int TAG_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        command,
    input  wire logic [15:0] request_size,
    input  wire logic [15:0] free_tag,
    output logic             done,
    output logic [1:0]       status,
    output logic [15:0]      assigned_tag,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;
    localparam logic [SIZE_BITS-1:0] HEAP_RST =
        (ffba_pkg::HEAP_RESET > SIZE_MAX) ? SIZE_MAX : SIZE_BITS'(ffba_pkg::HEAP_RESET);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] CYCLE_LAST = CW'(MAX_BLOCKS);

    // Chain signals
    logic                 c_valid [MAX_BLOCKS];
    logic                 c_free  [MAX_BLOCKS];
    logic [SIZE_BITS-1:0] c_size  [MAX_BLOCKS];
    logic [TAG_BITS-1:0]  c_tag   [MAX_BLOCKS];
    logic                 n_valid [MAX_BLOCKS];
    logic                 n_free  [MAX_BLOCKS];
    logic [SIZE_BITS-1:0] n_size  [MAX_BLOCKS];
    logic [TAG_BITS-1:0]  n_tag   [MAX_BLOCKS];

    ffba_pkg::state_t state_reg, state_next;

    logic                 cmd_reg;
    logic [SIZE_BITS-1:0] want_reg;
    logic [TAG_BITS-1:0]  ftag_reg;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [TAG_BITS-1:0]  next_tag_reg, next_tag_next;

    // Stream editor state
    logic                 pend_valid_reg, pend_valid_next;
    logic                 pend_free_reg, pend_free_next;
    logic [SIZE_BITS-1:0] pend_size_reg, pend_size_next;
    logic [TAG_BITS-1:0]  pend_tag_reg, pend_tag_next;
    logic                 extra_valid_reg, extra_valid_next;
    logic                 extra_free_reg, extra_free_next;
    logic [SIZE_BITS-1:0] extra_size_reg, extra_size_next;
    logic [TAG_BITS-1:0]  extra_tag_reg, extra_tag_next;
    logic                 dly2_reg, dly2_next;
    logic                 found_reg, found_next;
    logic                 full_reg, full_next;
    logic                 jf_reg, jf_next;
    logic [1:0]           del_reg, del_next;

    logic                 done_reg, done_next;
    logic [1:0]           status_reg, status_next;
    logic [15:0]          tag_out_reg, tag_out_next;

    logic                 push_en;
    logic                 shift;
    logic                 cfg_load;
    logic [31:0]          req_wide;
    logic [31:0]          cfg_wide;
    logic                 req_big;
    logic [SIZE_BITS-1:0] cfg_heap;
    logic [TAG_BITS-1:0]  tag_inc;

    assign req_wide = 32'(request_size);
    assign cfg_wide = 32'(cfg_data);
    assign req_big  = (req_wide >> SIZE_BITS) != 32'd0;
    assign cfg_heap = ((cfg_wide >> SIZE_BITS) != 32'd0) ? SIZE_MAX
                                                         : cfg_wide[SIZE_BITS-1:0];
    assign tag_inc  = next_tag_reg + TAG_BITS'(1);

    assign busy      = (state_reg != ffba_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == ffba_pkg::ST_IDLE);
    assign cfg_load  = cfg_valid && cfg_ready;
    assign shift     = (state_reg == ffba_pkg::ST_SCAN);

    // Chain of cells; the editor pushes at the tail or into the hole left by a merge
    for (genvar k = 0; k < MAX_BLOCKS; k++)
    begin : g_cell
        always_comb
        begin
            if (push_en && (int'(del_reg) == MAX_BLOCKS - 1 - k))
            begin
                n_valid[k] = pend_valid_reg;
                n_free[k]  = pend_free_reg;
                n_size[k]  = pend_size_reg;
                n_tag[k]   = pend_tag_reg;
            end
            else if (k == MAX_BLOCKS - 1)
            begin
                n_valid[k] = 1'b0;
                n_free[k]  = 1'b0;
                n_size[k]  = '0;
                n_tag[k]   = '0;
            end
            else
            begin
                n_valid[k] = c_valid[(k + 1) % MAX_BLOCKS];
                n_free[k]  = c_free[(k + 1) % MAX_BLOCKS];
                n_size[k]  = c_size[(k + 1) % MAX_BLOCKS];
                n_tag[k]   = c_tag[(k + 1) % MAX_BLOCKS];
            end
        end

        ffba_cell #(
            .SIZE_BITS   (SIZE_BITS),
            .TAG_BITS    (TAG_BITS),
            .RESET_VALID (k == 0),
            .RESET_SIZE  (HEAP_RST)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (shift),
            .load       (cfg_load),
            .load_valid (k == 0),
            .load_size  (cfg_heap),
            .in_valid   (n_valid[k]),
            .in_free    (n_free[k]),
            .in_size    (n_size[k]),
            .in_tag     (n_tag[k]),
            .valid      (c_valid[k]),
            .free       (c_free[k]),
            .size       (c_size[k]),
            .tag        (c_tag[k])
        );
    end

    // Hold state and editor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ffba_pkg::ST_IDLE;
            cnt_reg         <= '0;
            count_reg       <= CW'(1);
            next_tag_reg    <= TAG_BITS'(1);
            pend_valid_reg  <= 1'b0;
            extra_valid_reg <= 1'b0;
            dly2_reg        <= 1'b0;
            found_reg       <= 1'b0;
            full_reg        <= 1'b0;
            jf_reg          <= 1'b0;
            del_reg         <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            count_reg       <= cfg_load ? CW'(1) : count_next;
            next_tag_reg    <= next_tag_next;
            pend_valid_reg  <= pend_valid_next;
            extra_valid_reg <= extra_valid_next;
            dly2_reg        <= dly2_next;
            found_reg       <= found_next;
            full_reg        <= full_next;
            jf_reg          <= jf_next;
            del_reg         <= del_next;
            done_reg        <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_free_reg  <= pend_free_next;
        pend_size_reg  <= pend_size_next;
        pend_tag_reg   <= pend_tag_next;
        extra_free_reg <= extra_free_next;
        extra_size_reg <= extra_size_next;
        extra_tag_reg  <= extra_tag_next;
        status_reg     <= status_next;
        tag_out_reg    <= tag_out_next;
        if (start && !busy)
        begin
            cmd_reg  <= command;
            want_reg <= req_wide[SIZE_BITS-1:0];
            ftag_reg <= TAG_BITS'(32'(free_tag));
        end
    end

    // Next state, stream editing and results
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        count_next       = count_reg;
        next_tag_next    = next_tag_reg;
        pend_valid_next  = pend_valid_reg;
        pend_free_next   = pend_free_reg;
        pend_size_next   = pend_size_reg;
        pend_tag_next    = pend_tag_reg;
        extra_valid_next = extra_valid_reg;
        extra_free_next  = extra_free_reg;
        extra_size_next  = extra_size_reg;
        extra_tag_next   = extra_tag_reg;
        dly2_next        = dly2_reg;
        found_next       = found_reg;
        full_next        = full_reg;
        jf_next          = jf_reg;
        del_next         = del_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        tag_out_next     = tag_out_reg;
        push_en          = 1'b0;

        case (state_reg)
            ffba_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    extra_valid_next = 1'b0;
                    dly2_next       = 1'b0;
                    found_next      = 1'b0;
                    full_next       = 1'b0;
                    jf_next         = 1'b0;
                    del_next        = '0;
                    if (command == ffba_pkg::CMD_ALLOC && (request_size == 16'd0 || req_big))
                    begin
                        status_next  = ffba_pkg::STATUS_NOSPACE;
                        tag_out_next = '0;
                        done_next    = 1'b1;
                        state_next   = ffba_pkg::ST_DONE;
                    end
                    else
                        state_next = ffba_pkg::ST_SCAN;
                end
            end

            ffba_pkg::ST_SCAN:
            begin
                // Default: emit the held entry, hold the head entry
                push_en         = 1'b1;
                pend_valid_next = c_valid[0];
                pend_free_next  = c_free[0];
                pend_size_next  = c_size[0];
                pend_tag_next   = c_tag[0];
                jf_next         = 1'b0;
                if (dly2_reg)
                begin
                    pend_valid_next  = extra_valid_reg;
                    pend_free_next   = extra_free_reg;
                    pend_size_next   = extra_size_reg;
                    pend_tag_next    = extra_tag_reg;
                    extra_valid_next = c_valid[0];
                    extra_free_next  = c_free[0];
                    extra_size_next  = c_size[0];
                    extra_tag_next   = c_tag[0];
                end
                else if (cmd_reg == ffba_pkg::CMD_ALLOC)
                begin
                    if (!found_reg && c_valid[0] && c_free[0] && want_reg <= c_size[0])
                    begin
                        found_next = 1'b1;
                        if (want_reg != c_size[0] && count_reg == COUNT_MAX)
                            full_next = 1'b1;
                        else
                        begin
                            pend_free_next = 1'b0;
                            pend_size_next = want_reg;
                            pend_tag_next  = next_tag_reg;
                            if (want_reg != c_size[0])
                            begin
                                // Split: remainder follows as a free block
                                extra_valid_next = 1'b1;
                                extra_free_next  = 1'b1;
                                extra_size_next  = c_size[0] - want_reg;
                                extra_tag_next   = '0;
                                dly2_next        = 1'b1;
                            end
                        end
                    end
                end
                else
                begin
                    if (!found_reg && c_valid[0] && !c_free[0] && c_tag[0] == ftag_reg)
                    begin
                        found_next     = 1'b1;
                        jf_next        = 1'b1;
                        pend_free_next = 1'b1;
                        pend_tag_next  = '0;
                        if (pend_valid_reg && pend_free_reg)
                        begin
                            // Merge into the free predecessor
                            push_en         = 1'b0;
                            del_next        = del_reg + 2'd1;
                            pend_valid_next = 1'b1;
                            pend_size_next  = pend_size_reg + c_size[0];
                        end
                    end
                    else if (jf_reg && c_valid[0] && c_free[0])
                    begin
                        // Merge the free successor into the released block
                        push_en         = 1'b0;
                        del_next        = del_reg + 2'd1;
                        pend_valid_next = 1'b1;
                        pend_free_next  = 1'b1;
                        pend_size_next  = pend_size_reg + c_size[0];
                        pend_tag_next   = '0;
                    end
                end

                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CYCLE_LAST)
                begin
                    state_next   = ffba_pkg::ST_DONE;
                    done_next    = 1'b1;
                    tag_out_next = '0;
                    if (cmd_reg == ffba_pkg::CMD_ALLOC)
                    begin
                        if (!found_reg)
                            status_next = ffba_pkg::STATUS_NOSPACE;
                        else if (full_reg)
                            status_next = ffba_pkg::STATUS_FULL;
                        else
                        begin
                            status_next   = ffba_pkg::STATUS_OK;
                            tag_out_next  = 16'(32'(next_tag_reg));
                            next_tag_next = (tag_inc == '0) ? TAG_BITS'(1) : tag_inc;
                            count_next    = count_reg + CW'(dly2_reg);
                        end
                    end
                    else
                    begin
                        status_next = found_reg ? ffba_pkg::STATUS_OK : ffba_pkg::STATUS_NOTAG;
                        count_next  = count_reg - CW'(del_reg);
                    end
                end
            end

            ffba_pkg::ST_DONE:
            begin
                state_next = ffba_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = ffba_pkg::ST_IDLE;
            end
        endcase
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign assigned_tag = tag_out_reg;

    // Result strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held");

    // Table never empty nor over capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(1)) && (count_reg <= COUNT_MAX))
        else $error("block count out of range");

    // At most two merges per free
    assert property (@(posedge clk) disable iff (!rst_n) del_reg <= 2'd2)
        else $error("too many merges");

    // Accepted request makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    // Split only happens on an allocate
    assert property (@(posedge clk) disable iff (!rst_n)
        dly2_reg |-> (cmd_reg == ffba_pkg::CMD_ALLOC))
        else $error("split during free");

endmodule

`default_nettype wire
